/* hw/rtl/mseu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mseu_pkg;

  localparam int MemBytes = 1024;
  localparam int MemWords = MemBytes / 4;
  localparam int MemRows  = MemWords / 2;
  localparam int WordAw   = $clog2(MemWords);
  localparam int RowAw    = WordAw - 1;
  localparam int ByteAw   = WordAw + 2;

  localparam logic [RowAw-1:0] RowOne  = RowAw'(1);
  localparam logic [RowAw-1:0] RowLast = RowAw'(MemRows - 1);

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_NORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_HALT  = 6'h3f;

  // R-type functions
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_HALT    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // register write source chosen in stage 1
  localparam logic [1:0] WS_ALU  = 2'd0;
  localparam logic [1:0] WS_LOAD = 2'd1;
  localparam logic [1:0] WS_HI   = 2'd2;
  localparam logic [1:0] WS_LO   = 2'd3;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  shift_amount;
    logic [4:0]  dest_rd;
    logic [4:0]  dest_rt;
    logic [15:0] imm16;
    logic [25:0] jump_target;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] pc_plus4;
  } in_item_t;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [31:0] next_pc;
    logic [1:0]  status;
  } out_item_t;

  // stage 1 -> stage 2 control
  typedef struct packed {
    logic        reg_write;
    logic [4:0]  write_index;
    logic [31:0] alu_value;
    logic [31:0] next_pc;
    logic [1:0]  status;
    logic [1:0]  wsrc;
    logic [1:0]  lane;      // byte offset in word
    logic        odd_word;  // first word of the access sits in the odd bank
    logic [1:0]  ld_size;   // 0 byte, 1 half, 2 word
    logic        ld_signed;
  } exe_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/mips_subset_execute_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two register stages: decode and memory read, then load align into the output.
// Throughput: one item per cycle unless the output stalls; in_ready drops while
// the output holds and while the data memory is cleared after reset.
// Reset (rst, synchronous): clears HI, LO and control, then zeroes the data
// memory, one row of each bank per cycle over all 128 rows, with in_ready low.
module mips_subset_execute_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mseu_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mseu_pkg::out_item_t      out_item
);
  import mseu_pkg::*;

  exe_ctl_t           dctl, s1_ctl;
  logic               s1_valid, adv, take, clearing;
  logic               mem_rd, mem_wr, mul_en, mul_signed;
  logic [3:0]         be_even, be_odd;
  logic [31:0]        wdata_even, wdata_odd, rd_even, rd_odd;
  logic [31:0]        word_lo, word_hi, ld_val, wval;
  logic [63:0]        win;
  logic [RowAw-1:0]   row_even, row_odd, clr_row;
  logic [31:0]        hi_word, lo_word;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  mseu_decode u_dec (
    .in_item   (in_item),
    .ctl       (dctl),
    .mem_rd    (mem_rd),
    .mem_wr    (mem_wr),
    .row_even  (row_even),
    .row_odd   (row_odd),
    .be_even   (be_even),
    .be_odd    (be_odd),
    .wdata_even(wdata_even),
    .wdata_odd (wdata_odd),
    .mul_en    (mul_en),
    .mul_signed(mul_signed)
  );

  // stage 2 moves when output slot is free
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;
  assign take     = in_valid && in_ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + RowOne;
      if (clr_row == RowLast) clearing <= 1'b0;
    end
  end

  // read and write never overlap in one item, so no forwarding needed
  mseu_ram #(.Width(32), .Depth(MemRows)) u_ram_even (
    .clk  (clk),
    .we   (clearing || (take && mem_wr)),
    .be   (clearing ? 4'b1111 : be_even),
    .waddr(clearing ? clr_row : row_even),
    .wdata(clearing ? 32'd0 : wdata_even),
    .re   (take && mem_rd),
    .raddr(row_even),
    .rdata(rd_even)
  );

  mseu_ram #(.Width(32), .Depth(MemRows)) u_ram_odd (
    .clk  (clk),
    .we   (clearing || (take && mem_wr)),
    .be   (clearing ? 4'b1111 : be_odd),
    .waddr(clearing ? clr_row : row_odd),
    .wdata(clearing ? 32'd0 : wdata_odd),
    .re   (take && mem_rd),
    .raddr(row_odd),
    .rdata(rd_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl <= dctl;
    end
  end

  // one 33x33 signed multiplier serves mult and multu, registered into HI/LO
  assign mul_a = {mul_signed & in_item.rs_value[31], in_item.rs_value};
  assign mul_b = {mul_signed & in_item.rt_value[31], in_item.rt_value};
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_word <= '0;
      lo_word <= '0;
    end else if (take && mul_en) begin
      hi_word <= prod[63:32];
      lo_word <= prod[31:0];
    end
  end

  // load align (big-endian window over both banks)
  always_comb begin
    word_lo = s1_ctl.odd_word ? rd_odd : rd_even;
    word_hi = s1_ctl.odd_word ? rd_even : rd_odd;
    win     = {word_lo, word_hi} << {s1_ctl.lane, 3'b000};
    case (s1_ctl.ld_size)
      2'd2: ld_val = win[63:32];
      2'd1: begin
        ld_val = {16'd0, win[63:48]};
        if (s1_ctl.ld_signed) ld_val[31:16] = {16{ld_val[15]}};
      end
      default: begin
        ld_val = {24'd0, win[63:56]};
        if (s1_ctl.ld_signed) ld_val[31:8] = {24{ld_val[7]}};
      end
    endcase
    case (s1_ctl.wsrc)
      WS_LOAD: wval = ld_val;
      WS_HI:   wval = hi_word;
      WS_LO:   wval = lo_word;
      default: wval = s1_ctl.alu_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_item.reg_write   <= s1_ctl.reg_write;
      out_item.write_index <= s1_ctl.write_index;
      out_item.write_value <= wval;
      out_item.next_pc     <= s1_ctl.next_pc;
      out_item.status      <= s1_ctl.status;
    end
  end

`ifndef SYNTHESIS
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.reg_write |-> out_item.write_value == 32'd0
      && out_item.write_index == 5'd0) else $error("idle write fields");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(s1_valid) && out_valid)
    else $error("stage lost on stall");
  a_range_nowrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ctl.status == ST_RANGE |-> !s1_ctl.reg_write)
    else $error("out-of-range access writes");
`endif

endmodule
`default_nettype wire

/* hw/rtl/mseu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module mseu_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [Width/8-1:0]       be,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < Width / 8; i++) begin
        if (be[i]) mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/mseu_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
module mseu_decode (
  input  wire mseu_pkg::in_item_t in_item,
  output mseu_pkg::exe_ctl_t      ctl,
  output logic                    mem_rd,
  output logic                    mem_wr,
  output logic [mseu_pkg::RowAw-1:0] row_even,
  output logic [mseu_pkg::RowAw-1:0] row_odd,
  output logic [3:0]              be_even,
  output logic [3:0]              be_odd,
  output logic [31:0]             wdata_even,
  output logic [31:0]             wdata_odd,
  output logic                    mul_en,
  output logic                    mul_signed
);
  import mseu_pkg::*;

  logic [31:0] s, t, simm, zimm, addr, branch, jdest, sum;
  logic        slt_rt, slt_im, in_range, is_ld, is_st;
  logic [2:0]  size;
  logic [1:0]  lane;
  logic [WordAw-1:0] word_idx;
  logic [31:0] t_left;
  logic [63:0] st_data;
  logic [7:0]  st_mask;

  assign s      = in_item.rs_value;
  assign t      = in_item.rt_value;
  assign simm   = {{16{in_item.imm16[15]}}, in_item.imm16};
  assign zimm   = {16'd0, in_item.imm16};
  assign addr   = s + simm;
  assign branch = in_item.pc_plus4 + {simm[29:0], 2'b00};
  assign jdest  = {in_item.pc_plus4[31:28], in_item.jump_target, 2'b00};
  assign slt_rt = $signed(s) < $signed(t);
  assign slt_im = $signed(s) < $signed(simm);
  assign lane   = addr[1:0];

  // address check: non-negative and addr + size <= MemBytes
  always_comb begin
    sum      = addr + {29'd0, size};
    in_range = !addr[31] && (addr < 32'(MemBytes)) && (sum <= 32'(MemBytes));
  end

  always_comb begin
    ctl            = '0;
    ctl.next_pc    = in_item.pc_plus4;
    ctl.status     = ST_OK;
    ctl.wsrc       = WS_ALU;
    ctl.lane       = lane;
    ctl.odd_word   = addr[2];
    ctl.write_index = in_item.dest_rt;
    size           = 3'd0;
    is_ld          = 1'b0;
    is_st          = 1'b0;
    mul_en         = 1'b0;
    mul_signed     = 1'b0;
    if (in_item.opcode == OP_RTYPE) begin
      ctl.reg_write   = 1'b1;
      ctl.write_index = in_item.dest_rd;
      case (in_item.funct)
        FN_ADD, FN_ADDU: ctl.alu_value = s + t;
        FN_SUB:  ctl.alu_value = s - t;
        FN_AND:  ctl.alu_value = s & t;
        FN_OR:   ctl.alu_value = s | t;
        FN_XOR:  ctl.alu_value = s ^ t;
        FN_NOR:  ctl.alu_value = ~(s | t);
        FN_NAND: ctl.alu_value = ~(s & t);
        FN_SLT:  ctl.alu_value = {31'd0, slt_rt};
        FN_SLL:  ctl.alu_value = t << in_item.shift_amount;
        FN_SRL:  ctl.alu_value = t >> in_item.shift_amount;
        FN_SRA:  ctl.alu_value = 32'($signed(t) >>> in_item.shift_amount);
        FN_JR: begin
          ctl.reg_write = 1'b0;
          ctl.next_pc   = s;
        end
        FN_MULT, FN_MULTU: begin
          ctl.reg_write = 1'b0;
          mul_en        = 1'b1;
          mul_signed    = (in_item.funct == FN_MULT);
        end
        FN_MFHI: ctl.wsrc = WS_HI;
        FN_MFLO: ctl.wsrc = WS_LO;
        default: begin
          ctl.reg_write = 1'b0;
          ctl.status    = ST_ILLEGAL;
        end
      endcase
    end else begin
      case (in_item.opcode)
        OP_ADDI, OP_ADDIU: begin ctl.reg_write = 1'b1; ctl.alu_value = s + simm; end
        OP_ANDI: begin ctl.reg_write = 1'b1; ctl.alu_value = s & zimm; end
        OP_ORI:  begin ctl.reg_write = 1'b1; ctl.alu_value = s | zimm; end
        OP_NORI: begin ctl.reg_write = 1'b1; ctl.alu_value = ~(s | zimm); end
        OP_SLTI: begin ctl.reg_write = 1'b1; ctl.alu_value = {31'd0, slt_im}; end
        OP_LUI:  begin ctl.reg_write = 1'b1; ctl.alu_value = {in_item.imm16, 16'd0}; end
        OP_LW:  begin size = 3'd4; is_ld = 1'b1; ctl.ld_size = 2'd2; end
        OP_LH:  begin size = 3'd2; is_ld = 1'b1; ctl.ld_size = 2'd1; ctl.ld_signed = 1'b1; end
        OP_LHU: begin size = 3'd2; is_ld = 1'b1; ctl.ld_size = 2'd1; end
        OP_LB:  begin size = 3'd1; is_ld = 1'b1; ctl.ld_signed = 1'b1; end
        OP_LBU: begin size = 3'd1; is_ld = 1'b1; end
        OP_SW: begin size = 3'd4; is_st = 1'b1; end
        OP_SH: begin size = 3'd2; is_st = 1'b1; end
        OP_SB: begin size = 3'd1; is_st = 1'b1; end
        OP_BEQ:  if (s == t) ctl.next_pc = branch;
        OP_BNE:  if (s != t) ctl.next_pc = branch;
        OP_BGTZ: if ($signed(s) > 0) ctl.next_pc = branch;
        OP_J:    ctl.next_pc = jdest;
        OP_JAL: begin
          ctl.reg_write   = 1'b1;
          ctl.write_index = 5'd31;
          ctl.alu_value   = in_item.pc_plus4;
          ctl.next_pc     = jdest;
        end
        OP_HALT: ctl.status = ST_HALT;
        default: ctl.status = ST_ILLEGAL;
      endcase
    end
    // loads/stores that miss the memory do nothing
    if ((is_ld || is_st) && !in_range) begin
      ctl.status = ST_RANGE;
      is_ld      = 1'b0;
      is_st      = 1'b0;
    end
    if (is_ld) begin
      ctl.reg_write = 1'b1;
      ctl.wsrc      = WS_LOAD;
    end
    if (!ctl.reg_write) begin
      ctl.write_index = '0;
      ctl.alu_value   = '0;
      ctl.wsrc        = WS_ALU;
    end
  end

  // Words alternate between an even and an odd bank, so an unaligned access
  // touches word w and w+1 in different banks. The 8-byte window
  // {word w, word w+1} is big-endian: window byte 0 is bits 63:56.
  always_comb begin
    mem_rd   = is_ld;
    mem_wr   = is_st;
    word_idx = addr[ByteAw-1:2];
    case (size)
      3'd4: begin st_mask = 8'b1111_0000; t_left = t; end
      3'd2: begin st_mask = 8'b1100_0000; t_left = {t[15:0], 16'd0}; end
      default: begin st_mask = 8'b1000_0000; t_left = {t[7:0], 24'd0}; end
    endcase
    st_mask = st_mask >> lane;
    st_data = {t_left, 32'd0} >> {lane, 3'b000};
    row_odd  = word_idx[WordAw-1:1];
    row_even = word_idx[WordAw-1:1] + {{(RowAw-1){1'b0}}, word_idx[0]};
    if (word_idx[0]) begin
      be_odd     = st_mask[7:4];
      wdata_odd  = st_data[63:32];
      be_even    = st_mask[3:0];
      wdata_even = st_data[31:0];
    end else begin
      be_even    = st_mask[7:4];
      wdata_even = st_data[63:32];
      be_odd     = st_mask[3:0];
      wdata_odd  = st_data[31:0];
    end
  end

endmodule
`default_nettype wire
